// ===== rtl/plfc_pkg.sv =====
// ----------------------------------------------------------------------------
// plfc_pkg
// Shared types and constants for the long FIR convolver: field widths, op
// and register codes, and the control groups between sequencer and datapath.
// ----------------------------------------------------------------------------
package plfc_pkg;

  // field widths
  localparam int SAMPLE_W   = 24;
  localparam int OP_W       = 2;
  localparam int IDX_W      = 12;
  localparam int TAPCNT_W   = 13;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // datapath widths
  localparam int PROD_W = 2 * SAMPLE_W;
  localparam int ACC_W  = 64;

  // input word op codes
  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_LOAD   = 2'd1,
    OP_CLEAR  = 2'd2
  } plfc_op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE    = 2'd0,
    CFG_TAP_COUNT = 2'd1,
    CFG_GAIN      = 2'd2
  } plfc_cfg_t;

  // multiplier / accumulator control from the sequencer
  typedef struct packed {
    logic mul_en;    // register a product this cycle
    logic load_sel;  // coefficient times gain instead of tap times history
    logic acc_clr;   // start a new sum
    logic acc_en;    // add the registered product
  } plfc_mac_ctl_t;

  // result status from the sequencer
  typedef struct packed {
    logic emit;  // output register takes a word this cycle
    logic pass;  // word is the raw sample, not the filter sum
  } plfc_stat_t;

endpackage

// ===== rtl/plfc_if.sv =====
// ----------------------------------------------------------------------------
// plfc_in_if / plfc_out_if
// Valid/ready channels for input words and result words of the convolver.
// ----------------------------------------------------------------------------
interface plfc_in_if import plfc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            op;
  logic signed [SAMPLE_W-1:0] sample;
  logic [IDX_W-1:0]           coef_index;
  logic signed [SAMPLE_W-1:0] coef_value;

  modport source (output valid, op, sample, coef_index, coef_value, input ready);
  modport sink (input valid, op, sample, coef_index, coef_value, output ready);
endinterface

interface plfc_out_if import plfc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] filtered;

  modport source (output valid, filtered, input ready);
  modport sink (input valid, filtered, output ready);
endinterface

// ===== rtl/plfc_ram.sv =====
// ----------------------------------------------------------------------------
// plfc_ram
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module plfc_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 24,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/plfc_mac.sv =====
// ----------------------------------------------------------------------------
// plfc_mac
// Shared multiplier with a product register, wide accumulator, and the
// rounding and saturation for both coefficient scaling and filter output.
// ----------------------------------------------------------------------------
module plfc_mac import plfc_pkg::*; (
  input  logic                       clk,
  input  plfc_mac_ctl_t              ctl,
  input  logic signed [SAMPLE_W-1:0] tap_rd,
  input  logic signed [SAMPLE_W-1:0] hist_rd,
  input  logic signed [SAMPLE_W-1:0] coef,
  input  logic signed [GAIN_W-1:0]   gain,
  output logic signed [SAMPLE_W-1:0] scaled,
  output logic signed [SAMPLE_W-1:0] rounded
);

  localparam logic signed [ACC_W-1:0] S_MAX = (ACC_W'(1) <<< (SAMPLE_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] S_MIN = -S_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] OUT_HALF = ACC_W'(1) <<< (SAMPLE_W - 2);
  localparam logic signed [PROD_W-1:0] GAIN_HALF = PROD_W'(1) <<< (GAIN_FRAC - 1);

  logic signed [SAMPLE_W-1:0] op_a;
  logic signed [SAMPLE_W-1:0] op_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    out_shift;
  logic signed [PROD_W-1:0]   coef_shift;

  // clamp to the signed sample range
  function automatic logic signed [SAMPLE_W-1:0] sat_s(input logic signed [ACC_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > S_MAX) begin
      r = S_MAX[SAMPLE_W-1:0];
    end else if (v < S_MIN) begin
      r = S_MIN[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  // operand select
  always_comb begin
    if (ctl.load_sel) begin
      op_a = coef;
      op_b = {{(SAMPLE_W - GAIN_W){gain[GAIN_W-1]}}, gain};
    end else begin
      op_a = tap_rd;
      op_b = hist_rd;
    end
  end

  // product register
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= op_a * op_b;
    end
  end

  // accumulator; |sum| stays within tap_count * 2^46, well inside 64 bits
  always_ff @(posedge clk) begin
    if (ctl.acc_clr) begin
      acc <= '0;
    end else if (ctl.acc_en) begin
      acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  // round half up and saturate
  assign out_shift  = (acc + OUT_HALF) >>> (SAMPLE_W - 1);
  assign rounded    = sat_s(out_shift);
  assign coef_shift = (prod + GAIN_HALF) >>> GAIN_FRAC;
  assign scaled     = sat_s({{(ACC_W - PROD_W){coef_shift[PROD_W-1]}}, coef_shift});

endmodule

// ===== rtl/plfc_seq.sv =====
// ----------------------------------------------------------------------------
// plfc_seq
// Sequencer: takes input words, sweeps the history clear, walks the taps one
// per cycle through the shared multiplier and schedules coefficient loads.
// ----------------------------------------------------------------------------
module plfc_seq import plfc_pkg::*; #(
  parameter int MAX_TAPS = 4096,
  localparam int AW = $clog2(MAX_TAPS),
  localparam int CW = $clog2(MAX_TAPS + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  plfc_in_if.sink                    din,
  input  logic                       enable,
  input  logic [TAPCNT_W-1:0]        tap_count,
  input  logic                       out_free,
  output logic                       hist_we,
  output logic [AW-1:0]              hist_waddr,
  output logic signed [SAMPLE_W-1:0] hist_wdata,
  output logic [AW-1:0]              hist_raddr,
  output logic                       tap_we,
  output logic [AW-1:0]              tap_waddr,
  output logic [AW-1:0]              tap_raddr,
  output logic signed [SAMPLE_W-1:0] coef,
  output plfc_mac_ctl_t              mac_ctl,
  output plfc_stat_t                 stat
);

  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_TAPS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_EMIT,
    S_SCALE,
    S_STORE
  } state_t;

  state_t        state;
  logic [AW-1:0] wp;
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] clr_cnt;
  logic [AW-1:0] tap_idx;
  logic [CW-1:0] k;
  logic [CW-1:0] n_m1;
  logic [CW-1:0] n_m1_next;
  logic [31:0]   n_clamp;
  logic          v1;
  logic          v2;
  logic          pass;
  logic          accept;

  // tap count limited to 2 .. MAX_TAPS
  always_comb begin
    if (tap_count < TAPCNT_W'(2)) begin
      n_clamp = 32'd2;
    end else if (32'(tap_count) > 32'(MAX_TAPS)) begin
      n_clamp = 32'(MAX_TAPS);
    end else begin
      n_clamp = 32'(tap_count);
    end
    n_m1_next = CW'(n_clamp - 32'd1);
  end

  assign din.ready = (state == S_IDLE);
  assign accept    = din.valid && din.ready;

  // history port: clearing sweep or new sample at the write pointer
  assign hist_we    = (state == S_CLEAR) || (accept && din.op == OP_SAMPLE && enable);
  assign hist_waddr = (state == S_CLEAR) ? clr_cnt : wp;
  assign hist_wdata = (state == S_CLEAR) ? '0 : din.sample;
  assign hist_raddr = rd_ptr;

  // tap port
  assign tap_we    = (state == S_STORE);
  assign tap_waddr = tap_idx;
  assign tap_raddr = k[AW-1:0];

  // datapath control
  assign mac_ctl.mul_en   = v1 || (state == S_SCALE);
  assign mac_ctl.load_sel = (state == S_SCALE);
  assign mac_ctl.acc_clr  = accept;
  assign mac_ctl.acc_en   = v2;

  assign stat.emit = (state == S_EMIT) && out_free;
  assign stat.pass = pass;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      wp      <= '0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      pass    <= 1'b0;
    end else begin
      // read data valid, then product valid
      v1 <= (state == S_RUN);
      v2 <= v1;
      unique case (state)
        S_CLEAR: begin
          if (clr_cnt == LAST_SLOT) begin
            clr_cnt <= '0;
            wp      <= '0;
            state   <= S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + AW'(1);
          end
        end
        S_IDLE: begin
          if (din.valid) begin
            unique case (din.op)
              OP_SAMPLE: begin
                if (enable) begin
                  n_m1   <= n_m1_next;
                  k      <= '0;
                  rd_ptr <= wp;
                  pass   <= 1'b0;
                  state  <= S_RUN;
                end else begin
                  pass  <= 1'b1;
                  state <= S_EMIT;
                end
              end
              OP_LOAD: begin
                if (32'(din.coef_index) < 32'(MAX_TAPS)) begin
                  coef    <= din.coef_value;
                  tap_idx <= AW'(din.coef_index);
                  state   <= S_SCALE;
                end
              end
              OP_CLEAR: begin
                state <= S_CLEAR;
              end
              default: begin
              end
            endcase
          end
        end
        S_RUN: begin
          k      <= k + CW'(1);
          rd_ptr <= (rd_ptr == '0) ? LAST_SLOT : rd_ptr - AW'(1);
          if (k == n_m1) begin
            wp    <= (wp == LAST_SLOT) ? '0 : wp + AW'(1);
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!v1 && !v2) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_SCALE: begin
          state <= S_STORE;
        end
        S_STORE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/partitioned_long_fir_convolver_top.sv =====
// ----------------------------------------------------------------------------
// partitioned_long_fir_convolver_top
// Long FIR convolver for mono Q1.23 audio with gain-scaled coefficient loads.
// ----------------------------------------------------------------------------
// A sample word with enable set walks tap_count taps, with tap_count held to
// 2 .. MAX_TAPS: one tap is read from each memory and multiplied per cycle by
// the single shared multiplier, the pipeline drains, and the rounded, saturated
// sum is written to the output register from S_EMIT. With enable clear the
// sample is held and returned unchanged through S_EMIT. A result word that
// waits on a stalled receiver stays in the output register; the block goes on
// taking words but holds the next result in S_EMIT until that word is taken.
// A coefficient load passes through S_SCALE and S_STORE (it uses the same
// multiplier for the gain scaling). A clear word sweeps every slot of the
// history memory to zero, as reset does, before the next word is taken.
// Configuration writes are taken at any time but are meant for an idle block.
// ----------------------------------------------------------------------------
module partitioned_long_fir_convolver_top import plfc_pkg::*; #(
  parameter int MAX_TAPS = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  plfc_in_if.sink               din,
  plfc_out_if.source            dout
);

  localparam int AW = $clog2(MAX_TAPS);

  logic                       enable;
  logic [TAPCNT_W-1:0]        tap_count;
  logic signed [GAIN_W-1:0]   gain;

  logic                       hist_we;
  logic [AW-1:0]              hist_waddr;
  logic signed [SAMPLE_W-1:0] hist_wdata;
  logic [AW-1:0]              hist_raddr;
  logic signed [SAMPLE_W-1:0] hist_rd;
  logic                       tap_we;
  logic [AW-1:0]              tap_waddr;
  logic [AW-1:0]              tap_raddr;
  logic signed [SAMPLE_W-1:0] tap_rd;
  logic signed [SAMPLE_W-1:0] coef;
  logic signed [SAMPLE_W-1:0] scaled;
  logic signed [SAMPLE_W-1:0] rounded;
  logic signed [SAMPLE_W-1:0] sample_hold;
  plfc_mac_ctl_t              mac_ctl;
  plfc_stat_t                 stat;
  logic                       out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= 1'b0;
      tap_count <= TAPCNT_W'(2);
      gain      <= GAIN_W'(4096);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE:    enable    <= cfg_data[0];
        CFG_TAP_COUNT: tap_count <= cfg_data[TAPCNT_W-1:0];
        CFG_GAIN:      gain      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  plfc_seq #(
    .MAX_TAPS(MAX_TAPS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .din       (din),
    .enable    (enable),
    .tap_count (tap_count),
    .out_free  (out_free),
    .hist_we   (hist_we),
    .hist_waddr(hist_waddr),
    .hist_wdata(hist_wdata),
    .hist_raddr(hist_raddr),
    .tap_we    (tap_we),
    .tap_waddr (tap_waddr),
    .tap_raddr (tap_raddr),
    .coef      (coef),
    .mac_ctl   (mac_ctl),
    .stat      (stat)
  );

  plfc_ram #(
    .DEPTH(MAX_TAPS),
    .WIDTH(SAMPLE_W)
  ) u_hist_ram (
    .clk  (clk),
    .we   (hist_we),
    .waddr(hist_waddr),
    .wdata(hist_wdata),
    .raddr(hist_raddr),
    .rdata(hist_rd)
  );

  plfc_ram #(
    .DEPTH(MAX_TAPS),
    .WIDTH(SAMPLE_W)
  ) u_tap_ram (
    .clk  (clk),
    .we   (tap_we),
    .waddr(tap_waddr),
    .wdata(scaled),
    .raddr(tap_raddr),
    .rdata(tap_rd)
  );

  plfc_mac u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .tap_rd (tap_rd),
    .hist_rd(hist_rd),
    .coef   (coef),
    .gain   (gain),
    .scaled (scaled),
    .rounded(rounded)
  );

  // output register
  assign out_free = !dout.valid || dout.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (stat.emit) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
  end

  // payload: held sample for pass-through, else the filter word
  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      sample_hold <= din.sample;
    end
    if (stat.emit) begin
      dout.filtered <= stat.pass ? sample_hold : rounded;
    end
  end

endmodule
